/* rtl/lpht_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types, codes and constants of the linear probing hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

	localparam int CAPACITY_DEF   = 1024;
	localparam int KEY_W          = 31;
	localparam int SLOT_W         = 10;
	localparam int SIZE_W         = 11;
	localparam int STATUS_W       = 2;
	localparam int LOAD_W         = 9;
	localparam int CFG_IDX_W      = 1;
	localparam int CFG_DATA_W     = 11;
	localparam int START_SIZE_RST = 7;
	localparam int LOAD_LIMIT_RST = 192;

	// Remainder unit: dividend is the key padded to a whole number of digits.
	localparam int DIV_W     = 32;
	localparam int DIV_BITS  = 4;
	localparam int DIV_STEPS = DIV_W / DIV_BITS;
	localparam int DCNT_W    = $clog2(DIV_STEPS);

	localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_START_SIZE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOAD_LIMIT = 1'b1;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_SEARCH = 1'b1;

	typedef struct packed {
		logic             mode;
		logic [KEY_W-1:0] key;
	} in_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   slot;
		logic [SIZE_W-1:0]   size_in_use;
	} out_item_t;

	typedef struct packed {
		logic                take;
		logic                div_start;
		logic                div_step;
		logic                load_home;
		logic                probe_step;
		logic                write_key;
		logic                grow_begin;
		logic                clr_step;
		logic                scan_next;
		logic                rb_load;
		logic                grow_end;
		logic                emit;
		logic [STATUS_W-1:0] code;
	} cmd_t;

	typedef struct packed {
		logic mode;
		logic need_grow;
		logic full;
		logic div_last;
		logic used;
		logic match;
		logic tries_last;
		logic clr_last;
		logic scan_end;
		logic src_used;
		logic cfg_clear;
		logic out_free;
	} sts_t;

endpackage

/* rtl/lpht_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_ctrl
// Sequencer: clearing passes, lookup, insert and grow-and-rebuild steps.
// ----------------------------------------------------------------------------
module lpht_ctrl import lpht_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  sts_t sts,
	output cmd_t cmd,
	output logic idle
);

	typedef enum logic [12:0] {
		S_CLEAR  = 13'b0000000000001,
		S_IDLE   = 13'b0000000000010,
		S_CHECK  = 13'b0000000000100,
		S_PLACE  = 13'b0000000001000,
		S_DIV    = 13'b0000000010000,
		S_HOME   = 13'b0000000100000,
		S_PROBE  = 13'b0000001000000,
		S_EMIT   = 13'b0000010000000,
		S_GCLR   = 13'b0000100000000,
		S_GSCAN  = 13'b0001000000000,
		S_GDIV   = 13'b0010000000000,
		S_GHOME  = 13'b0100000000000,
		S_GPROBE = 13'b1000000000000
	} state_t;

	state_t              state_q, state_d;
	logic [STATUS_W-1:0] code_q, code_d;

	assign idle = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		code_d  = code_q;
		cmd     = '0;
		cmd.code = code_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.mode != MODE_INSERT) begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end else if (sts.need_grow) begin
					cmd.grow_begin = 1'b1;
					state_d        = S_GCLR;
				end else begin
					state_d = S_PLACE;
				end
			end
			S_PLACE: begin
				if (sts.full) begin
					code_d  = ST_FULL;
					state_d = S_EMIT;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_HOME;
				end
			end
			S_HOME: begin
				cmd.load_home = 1'b1;
				state_d       = S_PROBE;
			end
			S_PROBE: begin
				if (sts.mode == MODE_INSERT) begin
					if (!sts.used) begin
						cmd.write_key = 1'b1;
						code_d        = ST_INSERTED;
						state_d       = S_EMIT;
					end else begin
						cmd.probe_step = 1'b1;
					end
				end else if (!sts.used) begin
					code_d  = ST_NOT_FOUND;
					state_d = S_EMIT;
				end else if (sts.match) begin
					code_d  = ST_FOUND;
					state_d = S_EMIT;
				end else if (sts.tries_last) begin
					code_d  = ST_NOT_FOUND;
					state_d = S_EMIT;
				end else begin
					cmd.probe_step = 1'b1;
				end
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_GCLR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = S_GSCAN;
				end
			end
			S_GSCAN: begin
				if (sts.scan_end) begin
					cmd.grow_end = 1'b1;
					state_d      = S_PLACE;
				end else if (sts.src_used) begin
					cmd.rb_load = 1'b1;
					state_d     = S_GDIV;
				end else begin
					cmd.scan_next = 1'b1;
				end
			end
			S_GDIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_GHOME;
				end
			end
			S_GHOME: begin
				cmd.load_home = 1'b1;
				state_d       = S_GPROBE;
			end
			S_GPROBE: begin
				if (!sts.used) begin
					cmd.write_key = 1'b1;
					cmd.scan_next = 1'b1;
					state_d       = S_GSCAN;
				end else begin
					cmd.probe_step = 1'b1;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
		// A start size write restarts the clearing pass of the new table.
		if (sts.cfg_clear) begin
			state_d = S_CLEAR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			code_q  <= ST_INSERTED;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
		end
	end

endmodule

/* rtl/lpht_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_dp
// Datapath: two table banks, remainder unit, probe and scan pointers,
// configuration registers and the result register.
// ----------------------------------------------------------------------------
module lpht_dp import lpht_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_data
);

	localparam int AW         = $clog2(CAPACITY);
	localparam int SW         = $clog2(CAPACITY + 1);
	localparam int RW         = SW + 1;
	localparam int PW         = SW + LOAD_W;
	localparam int HALF       = CAPACITY / 2;
	localparam int RESET_SIZE = (START_SIZE_RST > CAPACITY) ? CAPACITY : START_SIZE_RST;
	localparam int WORD_W     = KEY_W + 1;

	logic [SW-1:0]     cur_size_q, count_q, tries_q, idx_q, idx_d, start_v;
	logic [LOAD_W-1:0] load_q;
	logic              bank_q, rebuild_q, tb;
	logic [AW-1:0]     pos_q, pos_d;
	logic [KEY_W-1:0]  key_q, rkey_q;
	logic              mode_q;
	logic [RW-1:0]     rem_q, rem_d;
	logic [DIV_W-1:0]  dvd_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic [WORD_W-1:0] mem0 [CAPACITY];
	logic [WORD_W-1:0] mem1 [CAPACITY];
	logic [WORD_W-1:0] rd0_q, rd1_q, rd_t, rd_s, wdata;
	logic [AW-1:0]     addr0, addr1;
	logic              we, pos_wrap, cfg_clear;
	logic [PW-1:0]     lhs, rhs;
	out_item_t         out_q;
	logic              out_valid_q;

	// Target bank receives writes and probes; the other one is the rebuild source.
	assign tb        = bank_q ^ rebuild_q;
	assign cfg_clear = cfg_valid && (cfg_index == CFG_START_SIZE);
	assign pos_wrap  = (SW'(pos_q) + SW'(1)) == cur_size_q;

	always_comb begin
		if (cfg_data == '0) begin
			start_v = SW'(1);
		end else if (32'(cfg_data) > CAPACITY) begin
			start_v = SW'(CAPACITY);
		end else begin
			start_v = SW'(cfg_data);
		end
	end

	always_comb begin
		if (cfg_clear || cmd.grow_begin) begin
			pos_d = '0;
		end else if (cmd.load_home) begin
			pos_d = AW'(rem_q);
		end else if (cmd.probe_step) begin
			pos_d = pos_wrap ? '0 : pos_q + AW'(1);
		end else if (cmd.clr_step) begin
			pos_d = pos_q + AW'(1);
		end else begin
			pos_d = pos_q;
		end
	end

	always_comb begin
		if (cmd.grow_begin) begin
			idx_d = '0;
		end else if (cmd.scan_next) begin
			idx_d = idx_q + SW'(1);
		end else begin
			idx_d = idx_q;
		end
	end

	// Remainder digits, DIV_BITS per cycle, restoring compare and subtract.
	always_comb begin
		rem_d = rem_q;
		for (int i = 0; i < DIV_BITS; i++) begin
			rem_d = {rem_d[RW-2:0], dvd_q[DIV_W-1-i]};
			if (rem_d >= {1'b0, cur_size_q}) begin
				rem_d = rem_d - {1'b0, cur_size_q};
			end
		end
	end

	// Memory banks: one write and one registered read each.
	assign addr0 = (tb == 1'b0) ? pos_d : AW'(idx_d);
	assign addr1 = (tb == 1'b1) ? pos_d : AW'(idx_d);
	assign we    = cmd.write_key || cmd.clr_step;
	assign wdata = cmd.write_key ? {1'b1, (rebuild_q ? rkey_q : key_q)} : '0;

	always_ff @(posedge clk) begin
		if (we && (tb == 1'b0)) begin
			mem0[pos_q] <= wdata;
		end
		rd0_q <= mem0[addr0];
	end

	always_ff @(posedge clk) begin
		if (we && (tb == 1'b1)) begin
			mem1[pos_q] <= wdata;
		end
		rd1_q <= mem1[addr1];
	end

	assign rd_t = tb ? rd1_q : rd0_q;
	assign rd_s = tb ? rd0_q : rd1_q;

	assign lhs = PW'({count_q, 8'b0});
	assign rhs = PW'(load_q) * PW'(cur_size_q);

	always_comb begin
		sts            = '0;
		sts.mode       = mode_q;
		sts.need_grow  = (lhs >= rhs) && (32'(cur_size_q) <= HALF);
		sts.full       = count_q >= cur_size_q;
		sts.div_last   = dcnt_q == DCNT_W'(DIV_STEPS - 1);
		sts.used       = rd_t[WORD_W-1];
		sts.match      = rd_t[KEY_W-1:0] == key_q;
		sts.tries_last = tries_q == (cur_size_q - SW'(1));
		sts.clr_last   = SW'(pos_q) == (cur_size_q - SW'(1));
		sts.scan_end   = idx_q == (cur_size_q >> 1);
		sts.src_used   = rd_s[WORD_W-1];
		sts.cfg_clear  = cfg_clear;
		sts.out_free   = !out_valid_q || !out_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_size_q  <= SW'(RESET_SIZE);
			load_q      <= LOAD_W'(LOAD_LIMIT_RST);
			count_q     <= '0;
			bank_q      <= 1'b0;
			rebuild_q   <= 1'b0;
			pos_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			pos_q <= pos_d;
			idx_q <= idx_d;
			if (cfg_clear) begin
				cur_size_q <= start_v;
				count_q    <= '0;
				rebuild_q  <= 1'b0;
			end else if (cmd.grow_begin) begin
				cur_size_q <= cur_size_q << 1;
				count_q    <= '0;
				rebuild_q  <= 1'b1;
			end else if (cmd.grow_end) begin
				bank_q    <= ~bank_q;
				rebuild_q <= 1'b0;
			end else if (cmd.write_key) begin
				count_q <= count_q + SW'(1);
			end
			if (cfg_valid && (cfg_index == CFG_LOAD_LIMIT)) begin
				load_q <= cfg_data[LOAD_W-1:0];
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			key_q  <= in_data.key;
			mode_q <= in_data.mode;
		end
		if (cmd.div_start) begin
			rem_q  <= '0;
			dvd_q  <= DIV_W'(key_q);
			dcnt_q <= '0;
		end else if (cmd.rb_load) begin
			rem_q  <= '0;
			dvd_q  <= DIV_W'(rd_s[KEY_W-1:0]);
			rkey_q <= rd_s[KEY_W-1:0];
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			rem_q  <= rem_d;
			dvd_q  <= dvd_q << DIV_BITS;
			dcnt_q <= dcnt_q + DCNT_W'(1);
		end
		if (cmd.load_home) begin
			tries_q <= '0;
		end else if (cmd.probe_step) begin
			tries_q <= tries_q + SW'(1);
		end
		if (cmd.emit) begin
			out_q.status      <= cmd.code;
			out_q.slot        <= ((cmd.code == ST_INSERTED) || (cmd.code == ST_FOUND)) ?
			                     SLOT_W'(pos_q) : '0;
			out_q.size_in_use <= SIZE_W'(cur_size_q);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

/* rtl/linear_probe_hash_table_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_table_top
// Open addressing hash table with linear probing, table growth and rebuild.
// ----------------------------------------------------------------------------
// Usage:
// An input beat (mode, key) is taken when in_valid is high and in_stall low.
// Mode 0 inserts the key, mode 1 searches for it. Each input beat yields one
// output beat (status, slot, size_in_use) on out_valid/out_stall.
// Items are processed one at a time: in_stall is low only while the
// sequencer is idle. A plain search computes its home slot, probes from there
// and then shows its result; the next beat can be taken once that result is
// loaded into the result register. An insert first passes a full check. The
// home slot comes from a remainder unit (4 quotient bits per cycle) and each
// probe reads one slot per cycle.
// An insert that triggers growth first clears the new table and then scans
// the old table, reinserting every old entry and skipping the empty old
// slots.
// The result register decouples the sides: the next beat is accepted while a
// result waits under out_stall; only the next result waits for it.
// After reset, and after each start_size write, a clearing pass over the
// slots of the current size runs while in_stall stays high. Configuration writes
// are always ready and are meant for idle periods.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_top import lpht_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;
	logic idle;

	// Registers take a write in any cycle.
	assign cfg_ready = 1'b1;

	// The sequencer takes a new beat only from its idle state.
	assign in_stall = !idle;

	lpht_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.sts      (sts),
		.cmd      (cmd),
		.idle     (idle)
	);

	lpht_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// Once a beat is taken, the block is busy in the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted twice in a row");

	// Misses and refusals always report slot zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((out_data.status == ST_NOT_FOUND) || (out_data.status == ST_FULL))
		|-> (out_data.slot == '0))
		else $error("nonzero slot on miss or refusal");

	// A key is only ever written into a free slot.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write_key |-> !sts.used)
		else $error("key written over an occupied slot");

	// A result is only loaded when the result register can take it.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("result register overwritten");

endmodule

/* verif/lpht_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_checker
// Watches the input, output and register channels of the hash table, keeps a
// model of its slots, predicts each result beat and compares it field by field.
// ----------------------------------------------------------------------------
module lpht_checker import lpht_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  in_item_t              in_data,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  out_item_t             out_data,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    pending
);

	localparam int SLOTS = CAPACITY_DEF;

	logic [KEY_W-1:0] slot_keys [SLOTS];
	logic             slot_used [SLOTS];
	logic [KEY_W-1:0] move_keys [SLOTS];
	logic             move_used [SLOTS];
	int               start_sz;
	int               grow_q8;
	int               n_entries;
	int               table_sz;
	out_item_t        lookup_results [$];

	assign pending = lookup_results.size();

	function automatic void wipe_table();
		for (int i = 0; i < SLOTS; i++) begin
			slot_used[i] = 1'b0;
			move_used[i] = 1'b0;
		end
		n_entries = 0;
		table_sz = start_sz;
	endfunction

	function automatic int store_key(logic [KEY_W-1:0] k);
		int pos;
		int tries;
		pos = int'(k % table_sz);
		tries = 0;
		while (slot_used[pos] && tries < table_sz) begin
			pos = (pos + 1) % table_sz;
			tries++;
		end
		slot_keys[pos] = k;
		slot_used[pos] = 1'b1;
		n_entries++;
		return pos;
	endfunction

	function automatic void double_table();
		int old_sz;
		int dummy;
		old_sz = table_sz;
		for (int i = 0; i < SLOTS; i++) begin
			move_keys[i] = slot_keys[i];
			move_used[i] = slot_used[i];
			slot_used[i] = 1'b0;
		end
		n_entries = 0;
		table_sz = old_sz * 2;
		for (int i = 0; i < old_sz; i++)
			if (move_used[i])
				dummy = store_key(move_keys[i]);
	endfunction

	function automatic out_item_t hash_lookup(in_item_t item);
		out_item_t r;
		int pos;
		int tries;
		r.slot = '0;
		if (item.mode == MODE_INSERT) begin
			if (n_entries * 256 >= grow_q8 * table_sz && table_sz * 2 <= SLOTS)
				double_table();
			if (n_entries >= table_sz) begin
				r.status = ST_FULL;
			end else begin
				r.slot = SLOT_W'(store_key(item.key));
				r.status = ST_INSERTED;
			end
		end else begin
			r.status = ST_NOT_FOUND;
			pos = int'(item.key % table_sz);
			tries = 0;
			while (tries < table_sz && slot_used[pos]) begin
				if (slot_keys[pos] == item.key) begin
					r.status = ST_FOUND;
					r.slot = SLOT_W'(pos);
					break;
				end
				pos = (pos + 1) % table_sz;
				tries++;
			end
		end
		r.size_in_use = SIZE_W'(table_sz);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		int v;
		if (!arst_n) begin
			start_sz = START_SIZE_RST;
			grow_q8 = LOAD_LIMIT_RST;
			wipe_table();
			lookup_results.delete();
			fail_count = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_START_SIZE) begin
					v = int'(cfg_data);
					if (v == 0)
						v = 1;
					if (v > SLOTS)
						v = SLOTS;
					start_sz = v;
					wipe_table();
				end else if (cfg_index == CFG_LOAD_LIMIT) begin
					grow_q8 = int'(cfg_data[LOAD_W-1:0]);
				end
			end
			// Retire the result first: it always belongs to an earlier beat.
			if (out_valid && !out_stall) begin
				if (lookup_results.size() == 0) begin
					$display("%0t: unexpected result beat %p", $time, out_data);
					fail_count++;
				end else begin
					want = lookup_results.pop_front();
					if (out_data.status !== want.status || out_data.slot !== want.slot ||
					    out_data.size_in_use !== want.size_in_use) begin
						$display("%0t: result mismatch expected %p actual %p",
							$time, want, out_data);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall)
				lookup_results.push_back(hash_lookup(in_data));
		end
	end

endmodule

/* verif/tb_linear_probe_hash_table_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_linear_probe_hash_table_top
// Drives inserts and searches through the hash table under several table
// sizes and growth thresholds, with random sender gaps and receiver stalls.
// The checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_linear_probe_hash_table_top;
	import lpht_pkg::*;

	// No beat moving on either channel for this many cycles means a hang.
	// The longest quiet stretch is a rebuild into 1024 slots plus a clear.
	localparam int QUIET_LIMIT = 50000;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	in_item_t              in_data;
	logic                  out_valid;
	logic                  out_stall;
	out_item_t             out_data;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    fail_count;
	int                    pending;
	int                    quiet_cycles;
	logic [KEY_W-1:0]      stored_keys [$];

	linear_probe_hash_table_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	lpht_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// The receiver switches between three moods in stretches of random length:
	// never stalling, stalling about half the time, and stalling most of the time.
	int stall_mood;
	int mood_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_mood <= 0;
			mood_left <= 0;
		end else begin
			if (mood_left == 0) begin
				stall_mood <= $urandom_range(0, 2);
				mood_left <= $urandom_range(1, 64);
			end else begin
				mood_left <= mood_left - 1;
			end
			case (stall_mood)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 1) == 1);
				default: out_stall <= ($urandom_range(0, 9) < 8);
			endcase
		end
	end

	// Watchdog: counts cycles in which no beat moves on either channel.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb_linear_probe_hash_table_top failed");
			$finish;
		end
	end

	// Presents one beat and holds it until the block takes it. Valid is left
	// high so that a following beat in the same burst goes out back to back.
	task automatic send_beat(input logic mode, input logic [KEY_W-1:0] k);
		in_valid <= 1'b1;
		in_data <= '{mode: mode, key: k};
		do @(posedge clk); while (in_stall);
		if (mode == MODE_INSERT)
			stored_keys.push_back(k);
	endtask

	// Closes a burst with a random gap; a zero gap keeps valid high.
	task automatic maybe_gap();
		int gap;
		if ($urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 12);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Registers are written only with the block idle: nothing outstanding.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(value);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_START_SIZE)
			stored_keys.delete();
	endtask

	function automatic logic [KEY_W-1:0] pick_key();
		case ($urandom_range(0, 3))
			0: return KEY_W'($urandom());
			1: return KEY_W'($urandom_range(0, 4095));
			default: return KEY_W'($urandom_range(0, 63));
		endcase
	endfunction

	// A run of random beats: mostly inserts early, then searches that hit
	// stored keys most of the time, with random keys mixed in as misses.
	task automatic random_phase(input int n_beats);
		logic [KEY_W-1:0] k;
		logic mode;
		for (int i = 0; i < n_beats; i++) begin
			mode = ($urandom_range(0, 99) < (i < n_beats / 2 ? 25 : 65));
			if (mode != MODE_INSERT && stored_keys.size() != 0 && $urandom_range(0, 9) < 7)
				k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
			else
				k = pick_key();
			send_beat(mode, k);
			maybe_gap();
		end
	endtask

	int sizes [10] = '{1, 2, 3, 5, 7, 8, 13, 16, 31, 64};
	int limits [9] = '{0, 1, 64, 128, 192, 255, 256, 257, 511};

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		quiet_cycles = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: collisions on the home slot, extreme keys, a duplicate.
		send_beat(MODE_INSERT, 31'd0);
		send_beat(MODE_INSERT, 31'd7);
		send_beat(MODE_INSERT, 31'h7FFF_FFFF);
		send_beat(MODE_INSERT, 31'd0);
		send_beat(MODE_SEARCH, 31'd0);
		send_beat(MODE_SEARCH, 31'd7);
		send_beat(MODE_SEARCH, 31'd14);
		send_beat(MODE_SEARCH, 31'h7FFF_FFFF);

		// Threshold above 256 never grows: fill a four-slot table, then a
		// refused insert and a search that wraps through every slot.
		write_reg(CFG_LOAD_LIMIT, 511);
		write_reg(CFG_START_SIZE, 4);
		send_beat(MODE_INSERT, 31'd1);
		send_beat(MODE_INSERT, 31'd5);
		send_beat(MODE_INSERT, 31'd9);
		send_beat(MODE_INSERT, 31'd13);
		send_beat(MODE_INSERT, 31'd2);
		send_beat(MODE_SEARCH, 31'd17);
		send_beat(MODE_SEARCH, 31'd13);

		// A zero threshold grows before every insert; a zero size reads as one.
		write_reg(CFG_LOAD_LIMIT, 0);
		write_reg(CFG_START_SIZE, 0);
		send_beat(MODE_INSERT, 31'd3);
		send_beat(MODE_INSERT, 31'd3);
		send_beat(MODE_INSERT, 31'h5555_5555);
		send_beat(MODE_SEARCH, 31'd3);

		// An oversized start size is clamped to the full capacity.
		write_reg(CFG_LOAD_LIMIT, 256);
		write_reg(CFG_START_SIZE, 2047);
		send_beat(MODE_INSERT, 31'd1023);
		send_beat(MODE_INSERT, 31'h2AAA_AAAA);
		send_beat(MODE_SEARCH, 31'd1023);
		send_beat(MODE_SEARCH, 31'h2AAA_AAAA);

		// Random phases, mostly with small tables so that they fill and grow.
		for (int p = 0; p < 12; p++) begin
			write_reg(CFG_LOAD_LIMIT, $urandom_range(0, 3) == 0 ?
				$urandom_range(0, 511) : limits[$urandom_range(0, 8)]);
			write_reg(CFG_START_SIZE, sizes[$urandom_range(0, 9)]);
			random_phase(34);
		end
		write_reg(CFG_LOAD_LIMIT, 192);
		write_reg(CFG_START_SIZE, 600);
		random_phase(20);
		write_reg(CFG_LOAD_LIMIT, 300);
		write_reg(CFG_START_SIZE, 1024);
		random_phase(20);

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("tb_linear_probe_hash_table_top passed");
		else
			$display("tb_linear_probe_hash_table_top failed");
		$finish;
	end

endmodule

/* sim.f */
rtl/lpht_pkg.sv
rtl/lpht_ctrl.sv
rtl/lpht_dp.sv
rtl/linear_probe_hash_table_top.sv
verif/lpht_checker.sv
verif/tb_linear_probe_hash_table_top.sv
